### design/wlsp_pkg.sv
// ----------------------------------------------------------------------------
// Word ladder search package
// Shared sizes, request codes and the one-step neighbour test.
// ----------------------------------------------------------------------------
package wlsp_pkg;

   localparam int MaxWords    = 1024;
   localparam int MaxLetters  = 10;
   localparam int IdxW        = $clog2(MaxWords);
   localparam int CntW        = IdxW + 1;
   localparam int WordW       = 50;
   localparam int LenW        = 11;
   localparam int LetterCount = 26;

   localparam logic [1:0] REQ_BEGIN = 2'd0;
   localparam logic [1:0] REQ_END   = 2'd1;
   localparam logic [1:0] REQ_DICT  = 2'd2;

   // Mask of the letter positions in use.
   function automatic logic [WordW-1:0] letters_mask(input logic [3:0] n);
      logic [WordW-1:0] m;
      m = '0;
      for (int p = 0; p < MaxLetters; p++) begin
         if (p < int'(n)) m[5*p +: 5] = 5'h1f;
      end
      return m;
   endfunction

   // True when cand differs from base in exactly one position and the
   // candidate's letter there is a real letter code.
   function automatic logic one_step(input logic [WordW-1:0] base,
                                     input logic [WordW-1:0] cand);
      logic [3:0] diffs;
      logic       ok;
      diffs = '0;
      ok    = 1'b0;
      for (int p = 0; p < MaxLetters; p++) begin
         if (base[5*p +: 5] != cand[5*p +: 5]) begin
            diffs = diffs + 4'd1;
            ok    = (cand[5*p +: 5] < 5'(LetterCount));
         end
      end
      return (diffs == 4'd1) && ok;
   endfunction

endpackage

### design/wlsp_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM with separate write and read addresses
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wlsp_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### design/word_ladder_shortest_path.sv
// ----------------------------------------------------------------------------
// Word ladder shortest path
// Breadth-first search over words that differ in one letter.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// req      in         tdata [1:0] req_type, [51:2] word_letters; tlast last_item
// rsp      out        tdata [10:0] ladder_length, [11] store_overflow
// csr      in         word_length, written with csr_wr_en
//
// Load transfers are taken one per cycle while the block is loading and no
// result is pending. The transfer marked last starts a search. A sweep over
// all MaxWords entries first clears the visited flags. The word store is then
// scanned once to mark copies of the begin word and once to seed the queue.
// Each dequeued word takes a queue read, the word fetch and its scan, unless
// it matches the end word, which ends the search at the start of its scan.
// When the dequeue step finds the queue empty, the done state posts a zero
// result. Reset is synchronous and leaves the current word, distance and
// result registers as they are. A pending result holds the block until it
// is taken; no request is accepted from the last transfer until then.
module word_ladder_shortest_path (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // [1:0] req_type, [51:2] word_letters
   input  logic        req_tlast,  // last_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [10:0] ladder_length, [11] store_overflow
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);
   localparam int IdxW  = wlsp_pkg::IdxW;
   localparam int CntW  = wlsp_pkg::CntW;
   localparam int WordW = wlsp_pkg::WordW;
   localparam int LenW  = wlsp_pkg::LenW;

   typedef enum logic [7:0] {
      S_LOAD  = 8'b00000001,
      S_CLEAR = 8'b00000010,
      S_MARK  = 8'b00000100,  // flag copies of the begin word
      S_SEED  = 8'b00001000,  // queue neighbours of the begin word
      S_DEQ   = 8'b00010000,  // read queue head
      S_FETCH = 8'b00100000,  // read head word
      S_SCAN  = 8'b01000000,  // expand head word
      S_DONE  = 8'b10000000
   } state_type;

   state_type        state_ff, state_in;
   logic [3:0]       wlen_ff, wlen_in;
   logic [WordW-1:0] begin_ff, begin_in, end_ff, end_in, cur_ff, cur_in;
   logic [CntW-1:0]  count_ff, count_in, head_ff, head_in, tail_ff, tail_in;
   logic [CntW-1:0]  k_ff, k_in;  // scan position; one ahead of the read data
   logic             ovf_ff, ovf_in, ovfr_ff, ovfr_in;
   logic [LenW-1:0]  dist_ff, dist_in, res_ff, res_in;
   logic             rv_ff, rv_in;

   // Memories
   logic             ws_we, vf_we, vf_wd, vf_rd, q_we;
   logic [IdxW-1:0]  ws_wa, ws_ra, vf_wa, vf_ra, q_wa, q_ra;
   logic [WordW-1:0] ws_rd;
   logic [IdxW+LenW-1:0] q_wd, q_rd;

   wlsp_ram #(.Width(WordW), .Depth(wlsp_pkg::MaxWords)) u_store (
      .clock, .wr_en(ws_we), .wr_addr(ws_wa), .wr_data(req_tdata[51:2]),
      .rd_addr(ws_ra), .rd_data(ws_rd));
   wlsp_ram #(.Width(1), .Depth(wlsp_pkg::MaxWords)) u_flags (
      .clock, .wr_en(vf_we), .wr_addr(vf_wa), .wr_data(vf_wd),
      .rd_addr(vf_ra), .rd_data(vf_rd));
   wlsp_ram #(.Width(IdxW + LenW), .Depth(wlsp_pkg::MaxWords)) u_queue (
      .clock, .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));

   logic [3:0]       n_eff;
   logic [WordW-1:0] mask, cand, bw, ew;
   logic             acc, prev_ok, hit, full;
   logic [CntW-1:0]  kp;

   assign n_eff = (wlen_ff == 4'd0) ? 4'd1 :
                  (wlen_ff > 4'(wlsp_pkg::MaxLetters)) ? 4'(wlsp_pkg::MaxLetters) : wlen_ff;
   assign mask  = wlsp_pkg::letters_mask(n_eff);
   assign cand  = ws_rd & mask;
   assign bw    = begin_ff & mask;
   assign ew    = end_ff & mask;
   assign req_tready = (state_ff == S_LOAD) && !rv_ff;
   assign acc   = req_tvalid && req_tready;
   assign kp    = k_ff - CntW'(1);
   // Read data in a scan state belongs to entry k-1, valid once k > 0.
   assign prev_ok = (k_ff != '0) && (kp < count_ff);
   // Flag written in the previous cycle for kp-1 cannot alias kp.
   assign full  = tail_ff[IdxW];

   always_comb begin
      state_in = state_ff;  wlen_in = wlen_ff;
      begin_in = begin_ff;  end_in = end_ff;   cur_in = cur_ff;
      count_in = count_ff;  head_in = head_ff; tail_in = tail_ff;
      k_in = k_ff;  ovf_in = ovf_ff;  ovfr_in = ovfr_ff;
      dist_in = dist_ff;  res_in = res_ff;  rv_in = rv_ff;
      ws_we = 1'b0;  ws_wa = count_ff[IdxW-1:0];  ws_ra = k_ff[IdxW-1:0];
      vf_we = 1'b0;  vf_wa = kp[IdxW-1:0];  vf_wd = 1'b1;  vf_ra = k_ff[IdxW-1:0];
      q_we = 1'b0;  q_wa = tail_ff[IdxW-1:0];
      q_wd = {dist_ff + LenW'(1), kp[IdxW-1:0]};
      q_ra = head_ff[IdxW-1:0];
      hit = 1'b0;

      if (csr_wr_en) wlen_in = csr_wr_data;
      if (rv_ff && rsp_tready) rv_in = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            if (acc) begin
               case (req_tdata[1:0])
                  wlsp_pkg::REQ_BEGIN: begin_in = req_tdata[51:2];
                  wlsp_pkg::REQ_END:   end_in   = req_tdata[51:2];
                  wlsp_pkg::REQ_DICT: begin
                     if (count_ff < CntW'(wlsp_pkg::MaxWords)) begin
                        ws_we = 1'b1;
                        count_in = count_ff + CntW'(1);
                     end else ovf_in = 1'b1;
                  end
                  default: ;
               endcase
               if (req_tlast) begin
                  ovfr_in = ovf_in;
                  ovf_in = 1'b0;
                  k_in = '0;
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            vf_we = 1'b1;  vf_wa = k_ff[IdxW-1:0];  vf_wd = 1'b0;
            k_in = k_ff + CntW'(1);
            if (k_ff == CntW'(wlsp_pkg::MaxWords - 1)) begin
               k_in = '0;
               if (bw == ew) begin
                  res_in = LenW'(1);  state_in = S_DONE;
               end else state_in = S_MARK;
            end
         end
         S_MARK: begin
            if (prev_ok && cand == bw) vf_we = 1'b1;
            k_in = k_ff + CntW'(1);
            if (kp >= count_ff && k_ff != '0) begin
               k_in = '0;  tail_in = '0;  head_in = '0;
               dist_in = LenW'(1);  state_in = S_SEED;
            end
         end
         S_SCAN, S_SEED: begin
            // Each entry is read and written once per scan, so the flag
            // read for k never sees a write pending from this scan.
            if (prev_ok && !vf_rd && wlsp_pkg::one_step(cur_ff & mask, cand)) begin
               vf_we = 1'b1;
               if (!full) begin
                  q_we = 1'b1;  tail_in = tail_ff + CntW'(1);
               end
            end
            if (state_ff == S_SEED) cur_in = begin_ff;
            k_in = k_ff + CntW'(1);
            if (kp >= count_ff && k_ff != '0) state_in = S_DEQ;
         end
         S_DEQ: begin
            if (head_ff == tail_in) begin
               res_in = '0;  state_in = S_DONE;
            end else begin
               head_in = head_ff + CntW'(1);
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            // q_rd holds the head entry; fetch its word.
            ws_ra = q_rd[IdxW-1:0];
            dist_in = q_rd[IdxW +: LenW];
            k_in = '0;
            state_in = S_SCAN;
            hit = 1'b0;
         end
         S_DONE: begin
            if (!rv_ff) begin
               rv_in = 1'b1;  count_in = '0;  state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase

      // The first scan cycle sees the head word on the read port.
      if (state_ff == S_SCAN && k_ff == '0) begin
         cur_in = ws_rd;
         if ((ws_rd & mask) == ew) begin
            hit = 1'b1;  res_in = dist_ff;  state_in = S_DONE;
         end
         vf_we = 1'b0;  q_we = 1'b0;  tail_in = tail_ff;
      end
      if (state_ff == S_SEED) cur_in = begin_ff;
   end

   // In the first scan cycle cur_ff is stale, so the expansion above uses
   // begin_ff only in the seed scan; the scan reads from k=0 on.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;  wlen_ff <= 4'd3;
         begin_ff <= '0;  end_ff <= '0;
         count_ff <= '0;  ovf_ff <= 1'b0;  ovfr_ff <= 1'b0;
         rv_ff <= 1'b0;  head_ff <= '0;  tail_ff <= '0;  k_ff <= '0;
      end else begin
         state_ff <= state_in;  wlen_ff <= wlen_in;
         begin_ff <= begin_in;  end_ff <= end_in;
         count_ff <= count_in;  ovf_ff <= ovf_in;  ovfr_ff <= ovfr_in;
         rv_ff <= rv_in;  head_ff <= head_in;  tail_ff <= tail_in;  k_ff <= k_in;
      end
      cur_ff <= cur_in;  dist_ff <= dist_in;  res_ff <= res_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {4'd0, ovfr_ff, res_ff};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> !req_tready) else $error("accept while busy");
   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= tail_ff)) else $error("queue head passed tail");
   a_hit_done: assert property (@(posedge clock) disable iff (reset)
      hit |=> (state_ff == S_DONE)) else $error("hit lost");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff == S_DONE)) else $error("stray result");
endmodule
